// File: rtl/plsv_pkg.sv
// Shared types, codes and name tables for the pane layout string validator.
package plsv_pkg;

    localparam int MAX_DEPTH_DEF = 256;
    localparam int NAME_COUNT    = 7;
    localparam int BASE_COUNT    = 5;
    localparam int NAME_SLOTS    = 24;

    localparam logic [1:0] NS_EITHER = 2'd0;
    localparam logic [1:0] NS_BASE   = 2'd1;
    localparam logic [1:0] NS_ALL    = 2'd2;
    localparam logic [1:0] NS_SPARE  = 2'd3;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_EMPTY        = 3'd1,
        ST_UNKNOWN_NAME = 3'd2,
        ST_BAD_HEX      = 3'd3,
        ST_SUM_MISMATCH = 3'd4,
        ST_MALFORMED    = 3'd5,
        ST_TOO_FEW      = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        PH_CELL  = 4'd0,
        PH_W     = 4'd1,
        PH_H0    = 4'd2,
        PH_H     = 4'd3,
        PH_X0    = 4'd4,
        PH_X     = 4'd5,
        PH_Y0    = 4'd6,
        PH_Y     = 4'd7,
        PH_ID0   = 4'd8,
        PH_ID    = 4'd9,
        PH_AFTER = 4'd10,
        PH_BAD   = 4'd11
    } t_phase;

    typedef struct packed {
        logic [7:0]  text_byte;
        logic        no_byte;
        logic        last;
        logic [15:0] min_panes;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic        needs_version;
        logic [15:0] cell_count;
    } t_result;

    // Names are left justified and padded with zero bytes.
    localparam logic [8*NAME_SLOTS-1:0] NAME_0 = {"even-horizontal", {9{8'h00}}};
    localparam logic [8*NAME_SLOTS-1:0] NAME_1 = {"even-vertical", {11{8'h00}}};
    localparam logic [8*NAME_SLOTS-1:0] NAME_2 = {"main-horizontal", {9{8'h00}}};
    localparam logic [8*NAME_SLOTS-1:0] NAME_3 = {"main-vertical", {11{8'h00}}};
    localparam logic [8*NAME_SLOTS-1:0] NAME_4 = {"tiled", {19{8'h00}}};
    localparam logic [8*NAME_SLOTS-1:0] NAME_5 = "main-horizontal-mirrored";
    localparam logic [8*NAME_SLOTS-1:0] NAME_6 = {"main-vertical-mirrored", {2{8'h00}}};

    function automatic logic [4:0] name_len(input logic [2:0] idx);
        logic [4:0] len;
        unique case (idx)
            3'd0: len = 5'd15;
            3'd1: len = 5'd13;
            3'd2: len = 5'd15;
            3'd3: len = 5'd13;
            3'd4: len = 5'd5;
            3'd5: len = 5'd24;
            3'd6: len = 5'd22;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [4:0] pos);
        logic [8*NAME_SLOTS-1:0] v;
        int                      off;
        logic [7:0]              ch;
        unique case (idx)
            3'd0: v = NAME_0;
            3'd1: v = NAME_1;
            3'd2: v = NAME_2;
            3'd3: v = NAME_3;
            3'd4: v = NAME_4;
            3'd5: v = NAME_5;
            3'd6: v = NAME_6;
            default: v = '0;
        endcase
        ch = 8'h00;
        if (pos < 5'(NAME_SLOTS)) begin
            off = 8 * (NAME_SLOTS - 1 - int'(pos));
            ch  = v[off +: 8];
        end
        return ch;
    endfunction

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] h;
        if (c >= "0" && c <= "9") begin
            h = {1'b0, 4'(c - 8'h30)};
        end else if (c >= "a" && c <= "f") begin
            h = {1'b0, 4'(c - 8'h57)};
        end else if (c >= "A" && c <= "F") begin
            h = {1'b0, 4'(c - 8'h37)};
        end else begin
            h = 5'b10000;
        end
        return h;
    endfunction

endpackage

// File: rtl/plsv_in_stage.sv
// Input register that holds one request for the parse stage.
module plsv_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  plsv_pkg::t_item i_item,
    input  logic            i_take,
    output logic            o_valid,
    output plsv_pkg::t_item o_item
);

    logic            r_valid;
    plsv_pkg::t_item r_item;

    // The register may refill in the same cycle its request moves on.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: rtl/plsv_parser.sv
// Per-string parse state, one byte step per cycle in which a byte fires, and the verdict logic.
module plsv_parser #(
    parameter int MAX_DEPTH = plsv_pkg::MAX_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  plsv_pkg::t_item   i_item,
    input  logic [1:0]        i_name_set,
    output plsv_pkg::t_result o_result
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic                 r_in_string;
    plsv_pkg::t_phase     r_phase, n_phase;
    logic [4:0]           r_pos, n_pos;
    logic [6:0]           r_prefix, n_prefix;
    logic [15:0]          r_exp, n_exp;
    logic [15:0]          r_sum, n_sum;
    logic [31:0]          r_num, n_num;
    logic [DW-1:0]        r_depth, n_depth;
    logic                 r_top;
    logic                 r_below;
    logic                 stk_mem [MAX_DEPTH];
    logic [AW-1:0]        rd_addr;
    logic [15:0]          r_leaf, n_leaf;
    logic [15:0]          r_goal, n_goal;
    logic [1:0]           r_flags, n_flags;

    logic [7:0]  c;
    logic [3:0]  dval;
    logic        is_dig;
    logic [35:0] mul_v;
    logic        add_ok;
    logic [15:0] leaf_inc;
    logic        close_ok;
    logic        open_ok;
    logic        do_push;
    logic        do_pop;
    logic        push_bit;
    logic [4:0]  hv;
    logic [15:0] rot;

    // Byte step: name prefix tracking, hex header, checksum and cell grammar.
    always_comb begin
        c        = i_item.text_byte;
        dval     = 4'(c - 8'h30);
        is_dig   = (c >= "0") && (c <= "9");
        mul_v    = ({4'b0, r_num} << 3) + ({4'b0, r_num} << 1) + 36'(dval);
        add_ok   = (mul_v[35:32] == 4'd0);
        leaf_inc = (r_leaf != 16'hffff) ? r_leaf + 16'd1 : r_leaf;
        close_ok = ((c == "]") || (c == "}")) && (r_depth != '0) && (r_top == (c == "}"));
        open_ok  = (r_depth < DW'(MAX_DEPTH));
        push_bit = (c == "{");
        hv       = plsv_pkg::hex_value(c);
        rot      = {r_sum[0], r_sum[15:1]};
        do_push  = 1'b0;
        do_pop   = 1'b0;
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_prefix = r_prefix;
        n_exp    = r_exp;
        n_sum    = r_sum;
        n_num    = r_num;
        n_depth  = r_depth;
        n_leaf   = r_leaf;
        n_goal   = r_goal;
        n_flags  = r_flags;
        if (i_fire) begin
            if (!r_in_string) begin
                n_goal = i_item.min_panes;
            end
            if (!i_item.no_byte) begin
                for (int i = 0; i < plsv_pkg::NAME_COUNT; i++) begin
                    if (r_pos >= plsv_pkg::name_len(3'(i)) ||
                        plsv_pkg::name_char(3'(i), r_pos) != c) begin
                        n_prefix[i] = 1'b0;
                    end
                end
                if (r_pos < 5'd4) begin
                    if (hv[4]) begin
                        n_flags[1] = 1'b1;
                    end else begin
                        n_exp = {r_exp[11:0], hv[3:0]};
                    end
                end else if (r_pos == 5'd4) begin
                    if (c != ",") begin
                        n_flags[0] = 1'b1;
                    end
                end else begin
                    n_sum = rot + {8'h00, c};
                    unique case (r_phase)
                        plsv_pkg::PH_CELL, plsv_pkg::PH_H0, plsv_pkg::PH_X0,
                        plsv_pkg::PH_Y0, plsv_pkg::PH_ID0: begin
                            if (!is_dig) begin
                                n_phase = plsv_pkg::PH_BAD;
                            end else begin
                                n_num = {28'h0, dval};
                                unique case (r_phase)
                                    plsv_pkg::PH_CELL: n_phase = plsv_pkg::PH_W;
                                    plsv_pkg::PH_H0:   n_phase = plsv_pkg::PH_H;
                                    plsv_pkg::PH_X0:   n_phase = plsv_pkg::PH_X;
                                    plsv_pkg::PH_Y0:   n_phase = plsv_pkg::PH_Y;
                                    default:           n_phase = plsv_pkg::PH_ID;
                                endcase
                            end
                        end
                        plsv_pkg::PH_W, plsv_pkg::PH_H, plsv_pkg::PH_X: begin
                            if (is_dig) begin
                                if (add_ok) n_num = mul_v[31:0];
                                else n_phase = plsv_pkg::PH_BAD;
                            end else if (r_phase == plsv_pkg::PH_W) begin
                                n_phase = (c == "x") ? plsv_pkg::PH_H0 : plsv_pkg::PH_BAD;
                            end else if (r_phase == plsv_pkg::PH_H) begin
                                n_phase = (c == ",") ? plsv_pkg::PH_X0 : plsv_pkg::PH_BAD;
                            end else begin
                                n_phase = (c == ",") ? plsv_pkg::PH_Y0 : plsv_pkg::PH_BAD;
                            end
                        end
                        plsv_pkg::PH_Y, plsv_pkg::PH_ID, plsv_pkg::PH_AFTER: begin
                            if (is_dig && r_phase != plsv_pkg::PH_AFTER) begin
                                if (add_ok) n_num = mul_v[31:0];
                                else n_phase = plsv_pkg::PH_BAD;
                            end else if (c == "," && r_phase == plsv_pkg::PH_Y) begin
                                n_phase = plsv_pkg::PH_ID0;
                            end else if (c == "x" && r_phase == plsv_pkg::PH_ID) begin
                                // An id followed by x was really the next sibling's width.
                                n_leaf  = leaf_inc;
                                n_phase = (r_depth != '0) ? plsv_pkg::PH_H0 : plsv_pkg::PH_BAD;
                            end else if ((c == "[" || c == "{") &&
                                         r_phase != plsv_pkg::PH_AFTER) begin
                                if (open_ok) begin
                                    do_push = 1'b1;
                                    n_phase = plsv_pkg::PH_CELL;
                                end else begin
                                    n_phase = plsv_pkg::PH_BAD;
                                end
                            end else begin
                                if (r_phase != plsv_pkg::PH_AFTER) n_leaf = leaf_inc;
                                if (c == ",") begin
                                    n_phase = (r_depth != '0) ? plsv_pkg::PH_CELL
                                                               : plsv_pkg::PH_BAD;
                                end else if (close_ok) begin
                                    do_pop  = 1'b1;
                                    n_phase = plsv_pkg::PH_AFTER;
                                end else begin
                                    n_phase = plsv_pkg::PH_BAD;
                                end
                            end
                        end
                        default: n_phase = plsv_pkg::PH_BAD;
                    endcase
                end
                if (r_pos != 5'd31) begin
                    n_pos = r_pos + 5'd1;
                end
            end
        end
        // Depth follows pushes and pops; the top entry lives in its own register.
        if (do_push) begin
            n_depth = r_depth + DW'(1);
        end else if (do_pop) begin
            n_depth = r_depth - DW'(1);
        end
    end

    // The entry just under the next top is read ahead for a later pop.
    assign rd_addr = (n_depth >= DW'(2)) ? AW'(n_depth - DW'(2)) : '0;

    logic        base_ok, all_ok, accepted;
    logic        exact5, exact7;
    logic [2:0]  cnt5, cnt7;
    logic [15:0] final_leaf;
    logic        tree_ok;

    // Verdict from the state after the final byte.
    always_comb begin
        exact5 = 1'b0;
        exact7 = 1'b0;
        for (int i = 0; i < plsv_pkg::NAME_COUNT; i++) begin
            if (n_prefix[i] && n_pos == plsv_pkg::name_len(3'(i))) begin
                exact7 = 1'b1;
                if (i < plsv_pkg::BASE_COUNT) exact5 = 1'b1;
            end
        end
        cnt5    = 3'($countones(n_prefix[4:0]));
        cnt7    = 3'($countones(n_prefix));
        base_ok = exact5 || (cnt5 == 3'd1);
        all_ok  = exact7 || (cnt7 == 3'd1);
        if (i_name_set == plsv_pkg::NS_BASE) accepted = base_ok;
        else if (i_name_set == plsv_pkg::NS_ALL) accepted = all_ok;
        else accepted = base_ok || all_ok;
        tree_ok = (n_depth == '0) && (n_phase == plsv_pkg::PH_Y ||
                  n_phase == plsv_pkg::PH_ID || n_phase == plsv_pkg::PH_AFTER);
        final_leaf = n_leaf;
        if (n_phase != plsv_pkg::PH_AFTER && n_leaf != 16'hffff) final_leaf = n_leaf + 16'd1;
        o_result.needs_version = (base_ok != all_ok);
        o_result.cell_count    = 16'd0;
        priority if (n_pos == 5'd0) begin
            o_result.status        = plsv_pkg::ST_EMPTY;
            o_result.needs_version = 1'b0;
        end else if (accepted) begin
            o_result.status = plsv_pkg::ST_OK;
        end else if (n_pos < 5'd6 || n_flags[0]) begin
            o_result.status = plsv_pkg::ST_UNKNOWN_NAME;
        end else if (n_flags[1]) begin
            o_result.status = plsv_pkg::ST_BAD_HEX;
        end else if (n_sum != n_exp) begin
            o_result.status = plsv_pkg::ST_SUM_MISMATCH;
        end else if (!tree_ok) begin
            o_result.status = plsv_pkg::ST_MALFORMED;
        end else begin
            o_result.cell_count = final_leaf;
            o_result.status = (final_leaf < n_goal) ? plsv_pkg::ST_TOO_FEW : plsv_pkg::ST_OK;
        end
    end

    // Control state; a final byte returns everything to the start of a string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string <= 1'b0;
            r_phase     <= plsv_pkg::PH_CELL;
            r_pos       <= '0;
            r_prefix    <= '1;
            r_exp       <= '0;
            r_sum       <= '0;
            r_num       <= '0;
            r_depth     <= '0;
            r_leaf      <= '0;
            r_goal      <= '0;
            r_flags     <= '0;
        end else if (i_fire && i_item.last) begin
            r_in_string <= 1'b0;
            r_phase     <= plsv_pkg::PH_CELL;
            r_pos       <= '0;
            r_prefix    <= '1;
            r_exp       <= '0;
            r_sum       <= '0;
            r_num       <= '0;
            r_depth     <= '0;
            r_leaf      <= '0;
            r_goal      <= '0;
            r_flags     <= '0;
        end else begin
            r_in_string <= r_in_string || i_fire;
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_prefix    <= n_prefix;
            r_exp       <= n_exp;
            r_sum       <= n_sum;
            r_num       <= n_num;
            r_depth     <= n_depth;
            r_leaf      <= n_leaf;
            r_goal      <= n_goal;
            r_flags     <= n_flags;
        end
    end

    // Bracket memory: a push writes one entry at the current depth, and the top and
    // the entry below it are kept in registers. Entries are only read below the
    // current depth, after they were written, so neither needs a reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            stk_mem[AW'(r_depth)] <= push_bit;
        end
        r_below <= stk_mem[rd_addr];
        if (do_push) begin
            r_top <= push_bit;
        end else if (do_pop) begin
            r_top <= r_below;
        end
    end

endmodule

// File: rtl/plsv_out_stage.sv
// Result register that holds one verdict until the consumer takes it.
module plsv_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  plsv_pkg::t_result i_result,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output plsv_pkg::t_result o_result
);

    logic              r_valid;
    plsv_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: rtl/pane_layout_string_validator.sv
// The final byte of a string passes the input register, and its verdict is then held in the result register.
// Throughput: one byte per cycle; the single parse stage updates all string state per byte.
// A final byte waits in the input register only while an earlier verdict is not taken.
// Reset (synchronous, active low) empties both registers, starts a new string and
// sets the name set to accept either set.
module pane_layout_string_validator #(
    parameter int MAX_DEPTH = plsv_pkg::MAX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_no_byte,
    input  logic        i_last,
    input  logic [15:0] i_min_panes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic        o_needs_version,
    output logic [15:0] o_cell_count
);

    logic              r_name_set;
    logic [1:0]        r_name_set_q;
    plsv_pkg::t_item   in_item, st_item;
    logic              st_valid, can_load, fire;
    plsv_pkg::t_result verdict, out_res;

    // Name-set register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_set_q <= plsv_pkg::NS_EITHER;
            r_name_set   <= 1'b0;
        end else if (i_cfg_we) begin
            r_name_set_q <= i_cfg_wdata;
            r_name_set   <= 1'b1;
        end
    end

    assign in_item = '{text_byte: i_text_byte, no_byte: i_no_byte, last: i_last,
                       min_panes: i_min_panes};

    // A byte moves on unless it is final and the result register is full and not being taken.
    assign fire = st_valid && (!st_item.last || can_load);

    plsv_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (st_valid),
        .o_item  (st_item)
    );

    plsv_parser #(.MAX_DEPTH(MAX_DEPTH)) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (st_item),
        .i_name_set (r_name_set_q),
        .o_result   (verdict)
    );

    plsv_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && st_item.last),
        .i_result   (verdict),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_res)
    );

    assign o_status        = out_res.status;
    assign o_needs_version = out_res.needs_version;
    assign o_cell_count    = out_res.cell_count;

    // A cell count is only reported with a custom layout verdict.
    a_cells_only_custom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cell_count != 16'd0 |->
            (o_status == plsv_pkg::ST_OK || o_status == plsv_pkg::ST_TOO_FEW))
        else $error("cell count reported with a non-layout status");

    // An empty string carries no other information.
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == plsv_pkg::ST_EMPTY |->
            (!o_needs_version && o_cell_count == 16'd0))
        else $error("empty verdict with extra fields");

    // Too few cells never reports a saturated count, since the count lies below a goal of at least one.
    a_too_few_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == plsv_pkg::ST_TOO_FEW |-> o_cell_count != 16'hffff)
        else $error("too few cells with a saturated count");

    // A held verdict blocks only a final byte, never an ordinary one.
    a_no_stall_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_valid && !st_item.last |-> o_in_ready)
        else $error("input stalled on a non-final byte");

    // The name-set flag tracks whether the register was written.
    a_cfg_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_name_set |-> r_name_set_q == plsv_pkg::NS_EITHER)
        else $error("name set changed without a write");

endmodule

// File: tb/pane_layout_string_checker.sv
// Checker for the pane layout string validator: predicts verdicts and compares them.
module pane_layout_string_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_no_byte,
    input  logic        i_last,
    input  logic [15:0] i_min_panes,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic        i_needs_version,
    input  logic [15:0] i_cell_count,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_verdicts
);

    localparam int DEPTH_LIMIT = plsv_pkg::MAX_DEPTH_DEF;

    // Copy of the per-string parser state.
    logic [1:0]        name_sel;
    logic              mid_string;
    plsv_pkg::t_phase  phase;
    logic [4:0]        char_pos;
    logic [6:0]        name_hits;
    logic [15:0]       header_sum;
    logic [15:0]       body_sum;
    logic [31:0]       num_val;
    int                depth;
    logic              brace_open [DEPTH_LIMIT];
    logic [15:0]       leaves;
    logic [15:0]       goal;
    logic [1:0]        hdr_errs;

    plsv_pkg::t_result verdict_q[$];
    int                status_seen[7];

    // Expected text of each arrangement name.
    function automatic string arrangement(input int i);
        case (i)
            0: return "even-horizontal";
            1: return "even-vertical";
            2: return "main-horizontal";
            3: return "main-vertical";
            4: return "tiled";
            5: return "main-horizontal-mirrored";
            default: return "main-vertical-mirrored";
        endcase
    endfunction

    function automatic bit is_dec(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic clear_string();
        mid_string = 1'b0;
        phase      = plsv_pkg::PH_CELL;
        char_pos   = '0;
        name_hits  = '1;
        header_sum = '0;
        body_sum   = '0;
        num_val    = '0;
        depth      = 0;
        leaves     = '0;
        goal       = '0;
        hdr_errs   = '0;
    endtask

    task automatic push_digit(input logic [7:0] c, input plsv_pkg::t_phase nxt);
        logic [63:0] v;
        v = 64'(num_val) * 10 + 64'(c - "0");
        if (v > 64'hffff_ffff) begin
            phase = plsv_pkg::PH_BAD;
        end else begin
            num_val = v[31:0];
            phase   = nxt;
        end
    endtask

    task automatic bump_leaves();
        if (leaves != 16'hffff) leaves++;
    endtask

    task automatic open_group(input logic [7:0] c);
        if (depth >= DEPTH_LIMIT) begin
            phase = plsv_pkg::PH_BAD;
        end else begin
            brace_open[depth] = (c == "{");
            depth++;
            phase = plsv_pkg::PH_CELL;
        end
    endtask

    task automatic close_cell(input logic [7:0] c);
        if (c == ",") begin
            phase = (depth != 0) ? plsv_pkg::PH_CELL : plsv_pkg::PH_BAD;
        end else if ((c == "]" || c == "}") && depth > 0
                     && brace_open[depth-1] == (c == "}")) begin
            depth--;
            phase = plsv_pkg::PH_AFTER;
        end else begin
            phase = plsv_pkg::PH_BAD;
        end
    endtask

    task automatic first_digit(input logic [7:0] c, input plsv_pkg::t_phase nxt);
        if (!is_dec(c)) begin
            phase = plsv_pkg::PH_BAD;
        end else begin
            num_val = '0;
            push_digit(c, nxt);
        end
    endtask

    // Grammar step for one body character.
    task automatic parse_body(input logic [7:0] c);
        case (phase)
            plsv_pkg::PH_CELL: first_digit(c, plsv_pkg::PH_W);
            plsv_pkg::PH_H0:   first_digit(c, plsv_pkg::PH_H);
            plsv_pkg::PH_X0:   first_digit(c, plsv_pkg::PH_X);
            plsv_pkg::PH_Y0:   first_digit(c, plsv_pkg::PH_Y);
            plsv_pkg::PH_ID0:  first_digit(c, plsv_pkg::PH_ID);
            plsv_pkg::PH_W: begin
                if (is_dec(c)) push_digit(c, plsv_pkg::PH_W);
                else phase = (c == "x") ? plsv_pkg::PH_H0 : plsv_pkg::PH_BAD;
            end
            plsv_pkg::PH_H: begin
                if (is_dec(c)) push_digit(c, plsv_pkg::PH_H);
                else phase = (c == ",") ? plsv_pkg::PH_X0 : plsv_pkg::PH_BAD;
            end
            plsv_pkg::PH_X: begin
                if (is_dec(c)) push_digit(c, plsv_pkg::PH_X);
                else phase = (c == ",") ? plsv_pkg::PH_Y0 : plsv_pkg::PH_BAD;
            end
            plsv_pkg::PH_Y: begin
                if (is_dec(c)) push_digit(c, plsv_pkg::PH_Y);
                else if (c == ",") phase = plsv_pkg::PH_ID0;
                else if (c == "[" || c == "{") open_group(c);
                else begin
                    bump_leaves();
                    close_cell(c);
                end
            end
            plsv_pkg::PH_ID: begin
                if (is_dec(c)) push_digit(c, plsv_pkg::PH_ID);
                else if (c == "x") begin
                    bump_leaves();
                    phase = (depth != 0) ? plsv_pkg::PH_H0 : plsv_pkg::PH_BAD;
                end else if (c == "[" || c == "{") open_group(c);
                else begin
                    bump_leaves();
                    close_cell(c);
                end
            end
            plsv_pkg::PH_AFTER: close_cell(c);
            default:  phase = plsv_pkg::PH_BAD;
        endcase
    endtask

    task automatic take_byte(input logic [7:0] c);
        string       nm;
        logic [4:0]  h;
        logic [15:0] r;
        for (int i = 0; i < 7; i++) begin
            nm = arrangement(i);
            if (char_pos >= nm.len() || nm[char_pos] != c) name_hits[i] = 1'b0;
        end
        if (char_pos < 4) begin
            h = plsv_pkg::hex_value(c);
            if (h[4]) hdr_errs[1] = 1'b1;
            else header_sum = {header_sum[11:0], h[3:0]};
        end else if (char_pos == 4) begin
            if (c != ",") hdr_errs[0] = 1'b1;
        end else begin
            r = {body_sum[0], body_sum[15:1]};
            body_sum = r + 16'(c);
            parse_body(c);
        end
        if (char_pos != 5'd31) char_pos++;
    endtask

    function automatic bit name_match(input int count);
        int    hits;
        bit    exact;
        string nm;
        hits  = 0;
        exact = 0;
        for (int i = 0; i < count; i++) begin
            if (name_hits[i]) begin
                nm = arrangement(i);
                if (char_pos == nm.len()) exact = 1;
                hits++;
            end
        end
        return exact || hits == 1;
    endfunction

    // Verdict for the string that just ended.
    task automatic finish_string(output plsv_pkg::t_result r);
        bit base_ok, all_ok, taken;
        r = '{status: plsv_pkg::ST_OK, needs_version: 1'b0, cell_count: 16'd0};
        if (char_pos == 0) begin
            r.status = plsv_pkg::ST_EMPTY;
        end else begin
            base_ok = name_match(plsv_pkg::BASE_COUNT);
            all_ok  = name_match(plsv_pkg::NAME_COUNT);
            r.needs_version = base_ok != all_ok;
            if (name_sel == plsv_pkg::NS_BASE) taken = base_ok;
            else if (name_sel == plsv_pkg::NS_ALL) taken = all_ok;
            else taken = base_ok || all_ok;
            if (taken) r.status = plsv_pkg::ST_OK;
            else if (char_pos < 6 || hdr_errs[0]) r.status = plsv_pkg::ST_UNKNOWN_NAME;
            else if (hdr_errs[1]) r.status = plsv_pkg::ST_BAD_HEX;
            else if (body_sum != header_sum) r.status = plsv_pkg::ST_SUM_MISMATCH;
            else if (depth != 0 || !(phase inside {plsv_pkg::PH_Y, plsv_pkg::PH_ID,
                                                   plsv_pkg::PH_AFTER}))
                r.status = plsv_pkg::ST_MALFORMED;
            else begin
                if (phase != plsv_pkg::PH_AFTER) bump_leaves();
                r.cell_count = leaves;
                r.status = (leaves < goal) ? plsv_pkg::ST_TOO_FEW : plsv_pkg::ST_OK;
            end
        end
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    // Track requests and verdicts at each clock edge.
    always @(posedge i_clk) begin
        plsv_pkg::t_result r, e;
        if (!i_rst_n) begin
            name_sel = plsv_pkg::NS_EITHER;
            clear_string();
            verdict_q.delete();
        end else begin
            if (i_cfg_we) name_sel = i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    report("unexpected verdict", {29'd0, i_status}, 0);
                end else begin
                    e = verdict_q.pop_front();
                    if (i_status != e.status) report("status", i_status, e.status);
                    if (i_needs_version != e.needs_version)
                        report("needs_version", i_needs_version, e.needs_version);
                    if (i_cell_count != e.cell_count)
                        report("cell_count", i_cell_count, e.cell_count);
                end
                o_verdicts++;
            end
            if (i_in_valid && i_in_ready) begin
                if (!mid_string) begin
                    goal = i_min_panes;
                    mid_string = 1'b1;
                end
                if (!i_no_byte) take_byte(i_text_byte);
                if (i_last) begin
                    finish_string(r);
                    status_seen[r.status]++;
                    verdict_q.push_back(r);
                    clear_string();
                end
            end
        end
        o_pending = verdict_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_verdicts   = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    end

    // Coverage line printed by the top before the verdict.
    function automatic void print_coverage();
        $display("verdicts by status ok/empty/name/hex/sum/tree/few: %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
    endfunction

endmodule

// File: tb/pane_layout_string_validator_tb.sv
// Testbench top for the pane layout string validator: stimulus, idling and verdict.
module pane_layout_string_validator_tb;

    localparam int LIMIT_CYCLES = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_text_byte;
    logic        i_no_byte;
    logic        i_last;
    logic [15:0] i_min_panes;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic        o_needs_version;
    logic [15:0] o_cell_count;

    int fail_count;
    int pending;
    int verdicts;
    int byte_total;
    int cycle_count;
    int stall_left;
    bit calm_tail;

    pane_layout_string_validator i_dut (.*);

    pane_layout_string_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_text_byte(i_text_byte),
        .i_no_byte(i_no_byte), .i_last(i_last), .i_min_panes(i_min_panes),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_status(o_status),
        .i_needs_version(o_needs_version), .i_cell_count(o_cell_count),
        .o_fail_count(fail_count), .o_pending(pending), .o_verdicts(verdicts)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit guards against a hang.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver stalls in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n || calm_tail) begin
            i_out_ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Send one request and hold it until it is accepted.
    task automatic send(input logic [7:0] c, input logic nb, input logic lst,
                        input logic [15:0] mp);
        int gap;
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= c;
        i_no_byte   <= nb;
        i_last      <= lst;
        i_min_panes <= mp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        byte_total++;
    endtask

    task automatic send_text(input string s, input logic [15:0] mp);
        if (s.len() == 0) begin
            send(8'h00, 1'b1, 1'b1, mp);
        end else begin
            for (int i = 0; i < s.len(); i++) send(s[i], 1'b0, i == s.len() - 1, mp);
        end
    endtask

    function automatic logic [15:0] bsd_sum(input string s);
        logic [15:0] r;
        r = '0;
        for (int i = 0; i < s.len(); i++) r = {r[0], r[15:1]} + 16'(s[i]);
        return r;
    endfunction

    // A body prefixed with its correct checksum.
    function automatic string framed(input string body);
        return {$sformatf("%04x", bsd_sum(body)), ",", body};
    endfunction

    function automatic string rand_cell();
        string s;
        s = $sformatf("%0dx%0d,%0d,%0d", $urandom_range(1, 300), $urandom_range(1, 300),
                      $urandom_range(0, 300), $urandom_range(0, 300));
        if ($urandom_range(0, 1)) s = {s, $sformatf(",%0d", $urandom_range(0, 99))};
        return s;
    endfunction

    // Random well-formed tree of limited depth.
    function automatic string rand_tree(input int lvl);
        string s;
        int    n;
        bit    brace;
        s = rand_cell();
        if (lvl < 3 && $urandom_range(0, 2) == 0) begin
            brace = $urandom_range(0, 1);
            n = $urandom_range(1, 3);
            s = {s, brace ? "{" : "["};
            for (int i = 0; i < n; i++) begin
                if (i > 0) s = {s, ","};
                s = {s, rand_tree(lvl + 1)};
            end
            s = {s, brace ? "}" : "]"};
        end
        return s;
    endfunction

    function automatic string mutate(input string s);
        int p;
        p = $urandom_range(0, s.len() - 1);
        s[p] = 8'($urandom_range(0, 255));
        return s;
    endfunction

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_names(input logic [1:0] v);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Empty strings and arrangement names and their prefixes.
    task automatic names_part();
        send_text("", 16'd0);
        send(8'h00, 1'b1, 1'b0, 16'd3);
        send_text("tiled", 16'hffff);
        send_text("main-vertical-mirrored", 16'd0);
        send_text("main-h", 16'd0);
        send_text("main-vertical-", 16'd0);
        send_text("even", 16'd0);
        send_text("t", 16'd0);
    endtask

    task automatic directed();
        string deep;
        deep = "1x1,0,0";
        for (int i = 0; i < 10; i++) deep = {deep, i[0] ? "{" : "[", "1x1,0,0"};
        for (int i = 9; i >= 0; i--) deep = {deep, i[0] ? "}" : "]"};
        names_part();
        send_text("zz12,1x1,0,0", 16'd0);
        send_text("abcd;1x1,0,0", 16'd0);
        send_text("0000,1x1,0,0", 16'd0);
        send_text(framed("10x20,0,0"), 16'd1);
        send_text(framed("10x20,0,0,5"), 16'd2);
        send_text(framed("1x1,0,0{1x1,0,0,7x2,3,4,5}"), 16'd0);
        send_text(framed("1x1,0,0,3x1,1,1"), 16'd0);
        send_text(framed("4294967296x1,0,0"), 16'd0);
        send_text(framed("4294967295x1,0,0"), 16'd0);
        send_text(framed("1x1,0,0[1x1,0,0}"), 16'd0);
        send_text(framed("1x1,0,0]"), 16'd0);
        send_text(framed("1x1,0,0[2x2,0,0]x"), 16'd0);
        send_text(framed(deep), 16'd12);
        send_text("FFFF,", 16'd0);
        send_text({"ABCD,", 8'h80, 8'hff}, 16'd0);
    endtask

    task automatic random_part(input int quota);
        string s;
        int    k;
        while (byte_total < quota) begin
            k = $urandom_range(0, 19);
            if (k < 9) s = framed(rand_tree(0));
            else if (k < 12) s = mutate(framed(rand_tree(0)));
            else if (k < 15) begin
                case ($urandom_range(0, 6))
                    0: s = "even-horizontal";
                    1: s = "even-vertical";
                    2: s = "main-horizontal";
                    3: s = "main-vertical";
                    4: s = "tiled";
                    5: s = "main-horizontal-mirrored";
                    default: s = "main-vertical-mirrored";
                endcase
                s = s.substr(0, $urandom_range(0, s.len() - 1));
            end else if (k < 17) begin
                s = "";
                for (int i = $urandom_range(0, 40); i > 0; i--)
                    s = {s, 8'($urandom_range(0, 255))};
            end else begin
                s = {$sformatf("%04X", $urandom_range(0, 65535)), ",", rand_tree(0)};
            end
            if ($urandom_range(0, 9) == 0 && s.len() > 0) begin
                send(8'($urandom), 1'b1, 1'b0, 16'($urandom));
            end
            send_text(s, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                         16'($urandom_range(0, 6)));
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= plsv_pkg::NS_EITHER;
        i_in_valid  <= 1'b0;
        i_text_byte <= 8'h00;
        i_no_byte   <= 1'b0;
        i_last      <= 1'b0;
        i_min_panes <= 16'h0000;
        i_out_ready <= 1'b1;
        byte_total  = 0;
        cycle_count = 0;
        stall_left  = 0;
        calm_tail   = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed();
        set_names(plsv_pkg::NS_BASE);
        names_part();
        random_part(byte_total + 220);
        set_names(plsv_pkg::NS_ALL);
        names_part();
        random_part(byte_total + 220);
        set_names(plsv_pkg::NS_SPARE);
        names_part();
        random_part(byte_total + 150);
        set_names(plsv_pkg::NS_EITHER);
        random_part(byte_total + 120);
        calm_tail = 1'b1;
        random_part(byte_total + 150);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("sent %0d bytes, checked %0d verdicts over all four name settings",
                 byte_total, verdicts);
        i_chk.print_coverage();
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
